[rtl/drle_pkg.sv]
`default_nettype none
package drle_pkg;

    // decimal digits kept for the run length; the count saturates at 10^COUNT_DIGITS - 1
    localparam int COUNT_DIGITS = 5;
    localparam int DIGIT_W      = 4;
    localparam int PTR_W        = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
    localparam int TDATA_W      = 8;

    localparam logic [DIGIT_W-1:0] BCD_NINE = DIGIT_W'(9);
    localparam logic [DIGIT_W-1:0] BCD_ONE  = DIGIT_W'(1);

    typedef logic [COUNT_DIGITS-1:0][DIGIT_W-1:0] t_bcd;

    // microprogram addresses
    typedef enum logic [2:0] {
        U_WAIT,
        U_EMIT_LEN,
        U_EMIT_SYM,
        U_LOAD,
        U_FLUSH
    } t_upc;

    // datapath operations
    typedef enum logic [2:0] {
        A_NOP,
        A_INC,
        A_LOAD_IN,
        A_LOAD_HELD,
        A_PTR_INIT,
        A_FLUSH_INIT,
        A_PTR_DEC,
        A_CLEAR
    } t_act;

    // next-address modes
    typedef enum logic [2:0] {
        J_DISPATCH,
        J_LEN,
        J_SYM,
        J_FINAL,
        J_NEXT
    } t_jmp;

    // output source
    typedef enum logic [1:0] {
        O_NONE,
        O_LEN,
        O_SYM
    } t_osel;

    typedef struct packed {
        logic  in_rdy;
        t_osel osel;
        t_act  act;
        t_jmp  jmp;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        logic latch;
        t_act act;
    } t_dp_ctl;

    typedef struct packed {
        logic run_open;
        logic match;
        logic ptr_zero;
        logic flush;
        logic held_final;
    } t_dp_stat;

    // control store
    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        w = '{in_rdy: 1'b0, osel: O_NONE, act: A_NOP, jmp: J_NEXT, target: U_WAIT};
        case (a)
            U_WAIT: begin
                w = '{in_rdy: 1'b1, osel: O_NONE, act: A_NOP, jmp: J_DISPATCH,
                      target: U_EMIT_LEN};
            end
            U_EMIT_LEN: begin
                w = '{in_rdy: 1'b0, osel: O_LEN, act: A_PTR_DEC, jmp: J_LEN,
                      target: U_EMIT_SYM};
            end
            U_EMIT_SYM: begin
                w = '{in_rdy: 1'b0, osel: O_SYM, act: A_CLEAR, jmp: J_SYM,
                      target: U_LOAD};
            end
            U_LOAD: begin
                w = '{in_rdy: 1'b0, osel: O_NONE, act: A_LOAD_HELD, jmp: J_FINAL,
                      target: U_FLUSH};
            end
            U_FLUSH: begin
                w = '{in_rdy: 1'b0, osel: O_NONE, act: A_FLUSH_INIT, jmp: J_NEXT,
                      target: U_EMIT_LEN};
            end
            default: begin
                w = '{in_rdy: 1'b0, osel: O_NONE, act: A_NOP, jmp: J_NEXT,
                      target: U_WAIT};
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/drle_datapath.sv]
`default_nettype none
module drle_datapath
    import drle_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_ctl            i_ctl,
    input  wire logic [DIGIT_W-1:0] i_in_digit,
    input  wire logic               i_in_final,
    output t_dp_stat                o_stat,
    output logic [DIGIT_W-1:0]      o_len_digit,
    output logic [DIGIT_W-1:0]      o_run_digit
);

    logic               r_open, n_open;
    logic               r_flush, n_flush;
    logic [DIGIT_W-1:0] r_digit, n_digit;
    t_bcd               r_len, n_len;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic [DIGIT_W-1:0] r_held_digit;
    logic               r_held_final;

    t_bcd               len_inc;
    logic               len_sat;
    logic [PTR_W-1:0]   top_ptr;
    logic               carry;

    // saturating decimal increment, ripple over the digits
    always_comb begin
        len_sat = 1'b1;
        carry   = 1'b1;
        len_inc = r_len;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (r_len[i] != BCD_NINE) len_sat = 1'b0;
            if (carry) begin
                if (r_len[i] == BCD_NINE) begin
                    len_inc[i] = '0;
                end else begin
                    len_inc[i] = r_len[i] + BCD_ONE;
                    carry      = 1'b0;
                end
            end
        end
    end

    // most significant nonzero digit
    always_comb begin
        top_ptr = '0;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (r_len[i] != '0) top_ptr = PTR_W'(i);
        end
    end

    // operation decode
    always_comb begin
        n_open  = r_open;
        n_flush = r_flush;
        n_digit = r_digit;
        n_len   = r_len;
        n_ptr   = r_ptr;
        case (i_ctl.act)
            A_INC: begin
                if (!len_sat) n_len = len_inc;
            end
            A_LOAD_IN: begin
                n_digit = i_in_digit;
                n_len   = '0;
                n_len[0] = BCD_ONE;
                n_open  = 1'b1;
            end
            A_LOAD_HELD: begin
                n_digit = r_held_digit;
                n_len   = '0;
                n_len[0] = BCD_ONE;
                n_open  = 1'b1;
            end
            A_PTR_INIT: begin
                n_ptr = top_ptr;
            end
            A_FLUSH_INIT: begin
                n_ptr   = top_ptr;
                n_flush = 1'b1;
            end
            A_PTR_DEC: begin
                n_ptr = r_ptr - PTR_W'(1);
            end
            A_CLEAR: begin
                n_open  = 1'b0;
                n_flush = 1'b0;
                n_digit = '0;
                n_len   = '0;
            end
            default: begin
                n_open = r_open;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_flush <= 1'b0;
            r_digit <= '0;
            r_len   <= '0;
        end else begin
            r_open  <= n_open;
            r_flush <= n_flush;
            r_digit <= n_digit;
            r_len   <= n_len;
        end
    end

    // pointer and held item carry no reset
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_ctl.latch) begin
            r_held_digit <= i_in_digit;
            r_held_final <= i_in_final;
        end
    end

    assign o_stat.run_open   = r_open;
    assign o_stat.match      = r_open && (r_digit == i_in_digit);
    assign o_stat.ptr_zero   = (r_ptr == '0);
    assign o_stat.flush      = r_flush;
    assign o_stat.held_final = r_held_final;
    assign o_len_digit       = r_len[r_ptr];
    assign o_run_digit       = r_digit;

endmodule
`default_nettype wire

[rtl/drle_sequencer.sv]
`default_nettype none
module drle_sequencer
    import drle_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_final,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_osel         o_osel,
    output t_dp_ctl       o_ctl
);

    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   in_fire;
    logic   out_fire;

    assign uw       = ucode(r_upc);
    assign in_fire  = uw.in_rdy && i_in_valid;
    assign out_fire = (uw.osel != O_NONE) && i_out_ready;

    // next address
    always_comb begin
        n_upc = r_upc;
        case (uw.jmp)
            J_DISPATCH: begin
                if (in_fire) begin
                    if (i_stat.match || !i_stat.run_open) begin
                        n_upc = i_in_final ? U_FLUSH : U_WAIT;
                    end else begin
                        n_upc = uw.target;
                    end
                end
            end
            J_LEN: begin
                if (out_fire && i_stat.ptr_zero) n_upc = uw.target;
            end
            J_SYM: begin
                if (out_fire) n_upc = i_stat.flush ? U_WAIT : uw.target;
            end
            J_FINAL: begin
                n_upc = i_stat.held_final ? uw.target : U_WAIT;
            end
            J_NEXT: begin
                n_upc = uw.target;
            end
            default: begin
                n_upc = U_WAIT;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_ctl.latch = in_fire;
        o_ctl.act   = A_NOP;
        case (uw.jmp)
            J_DISPATCH: begin
                if (in_fire) begin
                    if (i_stat.match)          o_ctl.act = A_INC;
                    else if (!i_stat.run_open) o_ctl.act = A_LOAD_IN;
                    else                       o_ctl.act = A_PTR_INIT;
                end
            end
            J_LEN: begin
                if (out_fire && !i_stat.ptr_zero) o_ctl.act = uw.act;
            end
            J_SYM: begin
                if (out_fire && i_stat.flush) o_ctl.act = uw.act;
            end
            J_FINAL: begin
                o_ctl.act = uw.act;
            end
            J_NEXT: begin
                o_ctl.act = uw.act;
            end
            default: begin
                o_ctl.act = A_NOP;
            end
        endcase
    end

    assign o_in_ready  = uw.in_rdy;
    assign o_out_valid = (uw.osel != O_NONE);
    assign o_osel      = uw.osel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_WAIT;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule
`default_nettype wire

[rtl/digit_run_length_encoder_top.sv]
// Look-and-say encoder: one digit item in, runs out as length digits then the digit.
// An item that extends the open run bumps its count; the output side is idle meanwhile.
// A run-closing item sends the run length digits, high digit first, then the run digit.
// A final item flushes the last run; results go out one per cycle while tready is high.
// Input and output are never open at once: the microcode steps through one item at a time.
// Synchronous active-low reset returns to the wait step with no run open.
`default_nettype none
module digit_run_length_encoder_top
    import drle_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [TDATA_W-1:0] i_s_axis_tdata,   // [3:0] in_digit, [7:4] zero
    input  wire logic               i_s_axis_tlast,   // in_final
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [TDATA_W-1:0]      o_m_axis_tdata,   // [3:0] out_digit, [7:4] zero
    output logic [0:0]              o_m_axis_tuser,   // [0] burst_end
    output logic                    o_m_axis_tlast    // stream_end
);

    t_dp_ctl            ctl;
    t_dp_stat           stat;
    t_osel              osel;
    logic [DIGIT_W-1:0] len_digit;
    logic [DIGIT_W-1:0] run_digit;
    logic [DIGIT_W-1:0] out_digit;

    drle_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_final  (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_osel      (osel),
        .o_ctl       (ctl)
    );

    drle_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_in_digit  (i_s_axis_tdata[DIGIT_W-1:0]),
        .i_in_final  (i_s_axis_tlast),
        .o_stat      (stat),
        .o_len_digit (len_digit),
        .o_run_digit (run_digit)
    );

    // output mux; the run digit closes each run
    assign out_digit         = (osel == O_SYM) ? run_digit : len_digit;
    assign o_m_axis_tdata    = {{(TDATA_W-DIGIT_W){1'b0}}, out_digit};
    assign o_m_axis_tlast    = (osel == O_SYM) && stat.flush;
    assign o_m_axis_tuser[0] = (osel == O_SYM) && (stat.flush || !stat.held_final);

endmodule
`default_nettype wire

[rtl/drle_checker.sv]
`default_nettype none
module drle_checker
    import drle_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_s_axis_tready,
    input wire logic               o_m_axis_tvalid,
    input wire logic               i_m_axis_tready,
    input wire logic [TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [0:0]         o_m_axis_tuser,
    input wire logic               o_m_axis_tlast
);

    // one side at a time
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input and output open together");

    // end of stream always ends the burst
    a_last_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser[0])
        else $error("stream end without burst end");

    // a burst end returns to accepting input, directly or after one load step
    a_burst_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser[0])
        |-> ##[1:2] o_s_axis_tready)
        else $error("not ready after burst end");

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("output changed under stall");

endmodule

bind digit_run_length_encoder_top drle_checker u_chk (.*);
`default_nettype wire
